FILE: rtl/rvk_pkg.sv
// Shared types and constants for the run-length view kernel sum block.
// No dependencies; every module of the block but rvk_ram imports this package.
package rvk_pkg;

  localparam int ACTION_W  = 2;
  localparam int VALUE_W   = 32;
  localparam int LEN_W     = 16;
  localparam int WIDX_W    = 10;
  localparam int START_W   = 31;
  localparam int VWIDTH_W  = 11;
  localparam int SUM_W     = 64;
  localparam int STATUS_W  = 2;
  localparam int KLEN_W    = 11;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  localparam logic [KLEN_W-1:0] KLEN_RESET = 11'd1024;
  localparam logic              REG_KLEN   = 1'b0;  // word address of kernel_length

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_WEIGHT = 2'd2,
    ACT_EVAL   = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_CLIP  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BACK_RD,
    ST_BACK_CHK,
    ST_FWD_RD,
    ST_FWD_CHK,
    ST_RUN_RD,
    ST_RUN_CHK,
    ST_ACC,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic clr;  // zero the accumulator
    logic mul;  // capture a product
    logic acc;  // add the held product with saturation
  } mac_ctrl_t;

endpackage

FILE: rtl/rle_view_kernel_weighted_sum.sv
// Top level: command port, APB register port, sequencer, run and weight stores.
// Depends on rvk_pkg, rvk_ram and rvk_mac.
//
//   port group      direction  handshake                       payload
//   command word    in         start_i & !busy_o               action_i .. view_width_i
//   result word     out        done_o, one cycle, no stall     view_sum_o, status_o
//   register port   in/out     psel & penable & pwrite & pready paddr, pwdata, prdata
//
// Loads and empty views finish at acceptance: the result word shows on the
// next cycle, and a new command may be taken in that same cycle.
// A view keeps busy_o high for a time that grows with the view positions, the
// cursor search steps and the run boundaries crossed, the end of data counting as
// one; the single read port of the run stores and the shared MAC set this.
// Reset clears the run count, the search cursor and kernel_length (to 1024);
// results cannot be held off by the receiver.
module rle_view_kernel_weighted_sum #(
  parameter int MAX_RUNS     = 4096,
  parameter int KERNEL_DEPTH = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [rvk_pkg::ACTION_W-1:0]        action_i,
  input  logic signed [rvk_pkg::VALUE_W-1:0]  run_value_i,
  input  logic [rvk_pkg::LEN_W-1:0]           run_length_i,
  input  logic [rvk_pkg::WIDX_W-1:0]          weight_index_i,
  input  logic signed [rvk_pkg::VALUE_W-1:0]  weight_value_i,
  input  logic [rvk_pkg::START_W-1:0]         view_start_i,
  input  logic [rvk_pkg::VWIDTH_W-1:0]        view_width_i,
  output logic                                done_o,
  output logic signed [rvk_pkg::SUM_W-1:0]    view_sum_o,
  output logic [rvk_pkg::STATUS_W-1:0]        status_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rvk_pkg::APB_AW-1:0]          paddr,
  input  logic [rvk_pkg::APB_DW-1:0]          pwdata,
  output logic [rvk_pkg::APB_DW-1:0]          prdata,
  output logic                                pready
);
  import rvk_pkg::*;

  localparam int RIW   = $clog2(MAX_RUNS);
  localparam int RCW   = $clog2(MAX_RUNS + 1);
  localparam int END_W = RIW + LEN_W;
  localparam int POS_W = START_W + 1;
  localparam int CW    = (END_W > POS_W) ? END_W : POS_W;
  localparam int KIW   = (KERNEL_DEPTH > 1) ? $clog2(KERNEL_DEPTH) : 1;
  localparam int KCAP  = (KERNEL_DEPTH > 2047) ? 2047 : KERNEL_DEPTH;
  localparam logic [KLEN_W-1:0] KCAP_V = KLEN_W'(KCAP);

  state_e                  state_q, state_d;
  logic [RIW-1:0]          r_q, r_d, cursor_q, cursor_d, end_raddr;
  logic [VWIDTH_W-1:0]     k_q, k_d;
  logic [RCW-1:0]          count_q, count_d;
  logic [END_W-1:0]        last_end_q, last_end_d, new_end;
  logic [KLEN_W-1:0]       klen_q, klen_eff, wclip;
  logic [START_W-1:0]      start_q;
  logic [VWIDTH_W-1:0]     width_q;
  logic                    clip_q, ld_view, pos_q, pos_d;
  logic                    done_q, done_d;
  logic signed [SUM_W-1:0] sum_q, sum_d, acc_w;
  status_e                 status_q, status_d;
  mac_ctrl_t               mac_ctrl;
  logic                    run_we, wt_we, cfg_we;
  logic [END_W-1:0]        end_rd;
  logic signed [VALUE_W-1:0] val_rd, wt_rd;
  logic [CW-1:0]           end_ext, start_ext, pos_ext, last_ext, vstart_ext;
  logic [POS_W-1:0]        pos_w;
  logic                    last_run, last_pos;

  // register port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_KLEN);
  assign prdata = (paddr[2] == REG_KLEN) ? APB_DW'(klen_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q <= KLEN_RESET;
    end else if (cfg_we) begin
      klen_q <= pwdata[KLEN_W-1:0];
    end
  end

  assign klen_eff = (klen_q < KCAP_V) ? klen_q : KCAP_V;
  assign wclip    = (view_width_i > klen_eff) ? klen_eff : view_width_i;

  assign new_end    = last_end_q + END_W'(run_length_i);
  assign pos_w      = POS_W'(start_q) + POS_W'(k_q);
  assign end_ext    = CW'(end_rd);
  assign start_ext  = CW'(start_q);
  assign pos_ext    = CW'(pos_w);
  assign last_ext   = CW'(last_end_q);
  assign vstart_ext = CW'(view_start_i);
  assign last_run   = (RCW'(r_q) + RCW'(1)) >= count_q;
  assign last_pos   = (k_q + VWIDTH_W'(1)) == width_q;

  always_comb begin
    state_d    = state_q;
    r_d        = r_q;
    k_d        = k_q;
    cursor_d   = cursor_q;
    count_d    = count_q;
    last_end_d = last_end_q;
    done_d     = 1'b0;
    sum_d      = sum_q;
    status_d   = status_q;
    pos_d      = pos_q;
    mac_ctrl   = '0;
    run_we     = 1'b0;
    wt_we      = 1'b0;
    ld_view    = 1'b0;
    end_raddr  = r_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          sum_d    = '0;
          status_d = STAT_OK;
          unique case (action_e'(action_i))
            ACT_CLEAR: begin
              count_d    = '0;
              cursor_d   = '0;
              last_end_d = '0;
              done_d     = 1'b1;
            end
            ACT_APPEND: begin
              done_d = 1'b1;
              if (count_q >= RCW'(MAX_RUNS)) begin
                status_d = STAT_FULL;
              end else if (run_length_i != '0) begin
                run_we     = 1'b1;
                count_d    = count_q + RCW'(1);
                last_end_d = new_end;
              end
            end
            ACT_WEIGHT: begin
              done_d = 1'b1;
              wt_we  = (32'(weight_index_i) < 32'(KERNEL_DEPTH));
            end
            ACT_EVAL: begin
              if (wclip == '0 || count_q == '0 || vstart_ext > last_ext) begin
                done_d   = 1'b1;
                status_d = STAT_EMPTY;
              end else begin
                ld_view      = 1'b1;
                mac_ctrl.clr = 1'b1;
                k_d          = '0;
                r_d          = (RCW'(cursor_q) >= count_q) ? RIW'(count_q - RCW'(1))
                                                            : cursor_q;
                state_d      = ST_BACK_RD;
              end
            end
          endcase
        end
      end
      ST_BACK_RD: begin
        if (r_q == '0) begin
          state_d = ST_FWD_RD;
        end else begin
          end_raddr = r_q - RIW'(1);
          state_d   = ST_BACK_CHK;
        end
      end
      ST_BACK_CHK: begin
        if (end_ext >= start_ext) begin
          r_d     = r_q - RIW'(1);
          state_d = ST_BACK_RD;
        end else begin
          state_d = ST_FWD_RD;
        end
      end
      ST_FWD_RD: begin
        if (last_run) begin
          cursor_d = r_q;
          state_d  = ST_RUN_RD;
        end else begin
          state_d = ST_FWD_CHK;
        end
      end
      ST_FWD_CHK: begin
        if (end_ext < start_ext) begin
          r_d     = r_q + RIW'(1);
          state_d = ST_FWD_RD;
        end else begin
          cursor_d = r_q;
          state_d  = ST_RUN_RD;
        end
      end
      ST_RUN_RD: begin
        state_d = ST_RUN_CHK;
      end
      ST_RUN_CHK: begin
        if (pos_w == '0) begin
          // position zero holds no data but uses kernel slot zero
          k_d     = k_q + VWIDTH_W'(1);
          state_d = last_pos ? ST_DONE : ST_RUN_RD;
        end else if (end_ext < pos_ext) begin
          if (last_run) begin
            state_d = ST_DONE;
          end else begin
            r_d     = r_q + RIW'(1);
            state_d = ST_RUN_RD;
          end
        end else begin
          mac_ctrl.mul = 1'b1;
          pos_d        = !val_rd[VALUE_W-1] && (val_rd != '0);
          state_d      = ST_ACC;
        end
      end
      ST_ACC: begin
        mac_ctrl.acc = pos_q;
        k_d          = k_q + VWIDTH_W'(1);
        state_d      = last_pos ? ST_DONE : ST_RUN_RD;
      end
      ST_DONE: begin
        done_d   = 1'b1;
        sum_d    = acc_w;
        status_d = clip_q ? STAT_CLIP : STAT_OK;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      r_q        <= '0;
      k_q        <= '0;
      cursor_q   <= '0;
      count_q    <= '0;
      last_end_q <= '0;
      done_q     <= 1'b0;
      pos_q      <= 1'b0;
      status_q   <= STAT_OK;
      sum_q      <= '0;
    end else begin
      state_q    <= state_d;
      r_q        <= r_d;
      k_q        <= k_d;
      cursor_q   <= cursor_d;
      count_q    <= count_d;
      last_end_q <= last_end_d;
      done_q     <= done_d;
      pos_q      <= pos_d;
      status_q   <= status_d;
      sum_q      <= sum_d;
    end
  end

  // hold the view operands for the whole walk
  always_ff @(posedge clk_i) begin
    if (ld_view) begin
      start_q <= view_start_i;
      width_q <= wclip;
      clip_q  <= view_width_i > klen_eff;
    end
  end

  rvk_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_RUNS)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (run_we),
    .waddr_i (RIW'(count_q)),
    .wdata_i (run_value_i),
    .raddr_i (r_q),
    .rdata_o (val_rd)
  );

  rvk_ram #(.WIDTH(END_W), .DEPTH(MAX_RUNS)) u_end_ram (
    .clk_i   (clk_i),
    .we_i    (run_we),
    .waddr_i (RIW'(count_q)),
    .wdata_i (new_end),
    .raddr_i (end_raddr),
    .rdata_o (end_rd)
  );

  rvk_ram #(.WIDTH(VALUE_W), .DEPTH(KERNEL_DEPTH)) u_wt_ram (
    .clk_i   (clk_i),
    .we_i    (wt_we),
    .waddr_i (KIW'(weight_index_i)),
    .wdata_i (weight_value_i),
    .raddr_i (KIW'(k_q)),
    .rdata_o (wt_rd)
  );

  rvk_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .a_i    (val_rd),
    .b_i    (wt_rd),
    .acc_o  (acc_w)
  );

  assign busy_o     = (state_q != ST_IDLE);
  assign done_o     = done_q;
  assign view_sum_o = sum_q;
  assign status_o   = status_q;

endmodule

FILE: rtl/rvk_ram.sv
// Single write port, single registered read port memory.
// Used for the run value, run end and kernel weight stores; no package use.
module rvk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/rvk_mac.sv
// Shared multiply and saturating accumulate unit.
// Depends on rvk_pkg for widths, limits and the control struct.
module rvk_mac (
  input  logic                             clk_i,
  input  rvk_pkg::mac_ctrl_t               ctrl_i,
  input  logic signed [rvk_pkg::VALUE_W-1:0] a_i,
  input  logic signed [rvk_pkg::VALUE_W-1:0] b_i,
  output logic signed [rvk_pkg::SUM_W-1:0]   acc_o
);
  import rvk_pkg::*;

  logic signed [SUM_W-1:0] prod_d, prod_q;
  logic signed [SUM_W-1:0] acc_d, acc_q;
  logic signed [SUM_W-1:0] sum_w;
  logic                    ovf_w;

  assign prod_d = a_i * b_i;
  assign sum_w  = acc_q + prod_q;
  // overflow when both operands share a sign that the sum lost
  assign ovf_w  = (acc_q[SUM_W-1] == prod_q[SUM_W-1]) && (sum_w[SUM_W-1] != acc_q[SUM_W-1]);

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clr) begin
      acc_d = '0;
    end else if (ctrl_i.acc) begin
      if (ovf_w) begin
        acc_d = acc_q[SUM_W-1] ? SUM_MIN : SUM_MAX;
      end else begin
        acc_d = sum_w;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      prod_q <= prod_d;
    end
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

FILE: rtl/rvk_checker.sv
// Port-level checks for the run-length view kernel sum block, bound to the top.
// Depends on rvk_pkg for action and status codes.
module rvk_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start_i,
  input logic                             busy_o,
  input logic [rvk_pkg::ACTION_W-1:0]     action_i,
  input logic                             done_o,
  input logic signed [rvk_pkg::SUM_W-1:0] view_sum_o,
  input logic [rvk_pkg::STATUS_W-1:0]     status_o
);
  import rvk_pkg::*;

  // load commands answer on the very next cycle
  a_load_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (action_i != ACT_EVAL) |=> done_o)
    else $error("load command gave no result word");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result word shown while busy");

  a_walk_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("view walk ended without a result word");

  a_zero_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == STAT_FULL || status_o == STAT_EMPTY) |-> view_sum_o == '0)
    else $error("nonzero sum with full or empty status");

  a_full_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == STAT_FULL) |-> $past(start_i && !busy_o && (action_i == ACT_APPEND)))
    else $error("full status not caused by an append");

endmodule

bind rle_view_kernel_weighted_sum rvk_checker u_rvk_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .action_i   (action_i),
  .done_o     (done_o),
  .view_sum_o (view_sum_o),
  .status_o   (status_o)
);
